### hdl/lsag_pkg.sv
// Shared constants, register codes and configuration types of the letterbox address generator.
package lsag_pkg;

  localparam int FRAME_WIDTH    = 320;
  localparam int FRAME_HEIGHT   = 480;
  localparam int FRAME_LAST_ROW = FRAME_HEIGHT - 1;
  localparam int MAX_IMAGE_DIM  = 4096;

  localparam int DIM_W   = 13;
  localparam int COORD_W = 9;
  localparam int DRAW_W  = 21;
  localparam int OFF_W   = DRAW_W + 1;
  localparam int FIDX_W  = 18;
  localparam int SRC_W   = 12;
  localparam int LIN_W   = 24;
  localparam int ADDR_W  = 26;
  localparam int QUO_W   = 13;
  localparam int T_W     = 16;
  localparam int RECIP_W = 18;
  localparam int RECIP_SHIFT = 20;
  localparam int BPP_W   = 3;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // floor(p / 320) = floor(floor(p / 64) / 5), floor(p / 480) = floor(floor(p / 32) / 15).
  localparam logic [RECIP_W-1:0] RECIP_DIV5  = RECIP_W'(209716);
  localparam logic [RECIP_W-1:0] RECIP_DIV15 = RECIP_W'(69906);

  localparam logic [DIM_W-1:0] RESET_IMAGE_WIDTH  = DIM_W'(320);
  localparam logic [DIM_W-1:0] RESET_IMAGE_HEIGHT = DIM_W'(480);
  localparam logic [BPP_W-1:0] RESET_BPP          = BPP_W'(3);

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_BYTES_PER_PIXEL = 3'd2,
    REG_FILL_MODE       = 3'd3,
    REG_PORTRAIT        = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [BPP_W-1:0] bpp;
    logic             fill;
    logic             portrait;
  } cfg_t;

  typedef struct packed {
    logic [DRAW_W-1:0] draw_w;
    logic [DRAW_W-1:0] draw_h;
    logic [OFF_W-1:0]  off_x;
    logic [OFF_W-1:0]  off_y;
    logic [DIM_W-1:0]  den;
    logic              num480;
  } geom_t;

endpackage

### hdl/lsag_regs.sv
// Configuration register file with APB-style access and range clamping.
module lsag_regs import lsag_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o,
  output logic               wr_o
);

  logic [DIM_W-1:0] image_width_q;
  logic [DIM_W-1:0] image_height_q;
  logic [BPP_W-1:0] bpp_q;
  logic             fill_q;
  logic             portrait_q;
  reg_idx_e         idx;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_o   = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= RESET_IMAGE_WIDTH;
      image_height_q <= RESET_IMAGE_HEIGHT;
      bpp_q          <= RESET_BPP;
      fill_q         <= 1'b0;
      portrait_q     <= 1'b0;
    end else if (wr_o) begin
      unique case (idx)
        REG_IMAGE_WIDTH:     image_width_q  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    image_height_q <= pwdata[DIM_W-1:0];
        REG_BYTES_PER_PIXEL: bpp_q          <= pwdata[BPP_W-1:0];
        REG_FILL_MODE:       fill_q         <= pwdata[0];
        REG_PORTRAIT:        portrait_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IMAGE_WIDTH:     prdata = PDATA_W'(image_width_q);
      REG_IMAGE_HEIGHT:    prdata = PDATA_W'(image_height_q);
      REG_BYTES_PER_PIXEL: prdata = PDATA_W'(bpp_q);
      REG_FILL_MODE:       prdata = PDATA_W'(fill_q);
      REG_PORTRAIT:        prdata = PDATA_W'(portrait_q);
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    if (image_width_q == '0) begin
      cfg_o.width = DIM_W'(1);
    end else if (image_width_q > DIM_W'(MAX_IMAGE_DIM)) begin
      cfg_o.width = DIM_W'(MAX_IMAGE_DIM);
    end else begin
      cfg_o.width = image_width_q;
    end
    if (image_height_q == '0) begin
      cfg_o.height = DIM_W'(1);
    end else if (image_height_q > DIM_W'(MAX_IMAGE_DIM)) begin
      cfg_o.height = DIM_W'(MAX_IMAGE_DIM);
    end else begin
      cfg_o.height = image_height_q;
    end
    if (bpp_q == '0) begin
      cfg_o.bpp = BPP_W'(1);
    end else if (bpp_q > BPP_W'(4)) begin
      cfg_o.bpp = BPP_W'(4);
    end else begin
      cfg_o.bpp = bpp_q;
    end
    cfg_o.fill     = fill_q;
    cfg_o.portrait = portrait_q;
  end

endmodule

### hdl/lsag_geom.sv
// Sequencer that derives draw size, centering offsets and scale from the configuration.
module lsag_geom import lsag_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  start_i,
  output geom_t geom_o,
  output logic  busy_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OFFS = 3'd4;
  localparam logic [4:0] LAST_STEP = 5'(DRAW_W - 1);

  logic [2:0]        state_q, state_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              xs_q, xs_d;
  logic              use_x_q, use_x_d;
  logic              num480_q, num480_d;
  logic [DIM_W-1:0]  den_q, den_d;
  logic [DRAW_W-1:0] quo_q, quo_d;
  logic [11:0]       rem_q, rem_d;
  logic [DRAW_W-1:0] draw_w_q, draw_w_d, draw_h_q, draw_h_d;
  logic [OFF_W-1:0]  off_x_q, off_x_d, off_y_q, off_y_d;

  logic [COORD_W-1:0] dw, dh, num, other_disp;
  logic [DIM_W-1:0]   other;
  logic [21:0]        prod_a, prod_b, dvd;
  logic               use_x;
  logic [DIM_W-1:0]   trial;
  logic               ge;
  logic signed [OFF_W-1:0] diff_x, diff_y, adj_x, adj_y;

  assign dw = cfg_i.portrait ? COORD_W'(FRAME_WIDTH) : COORD_W'(FRAME_HEIGHT);
  assign dh = cfg_i.portrait ? COORD_W'(FRAME_HEIGHT) : COORD_W'(FRAME_WIDTH);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    xs_d     = xs_q;
    use_x_d  = use_x_q;
    num480_d = num480_q;
    den_d    = den_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    draw_w_d = draw_w_q;
    draw_h_d = draw_h_q;
    off_x_d  = off_x_q;
    off_y_d  = off_y_q;

    prod_a = dw * cfg_i.height;
    prod_b = dh * cfg_i.width;
    use_x  = cfg_i.fill ? !xs_q : xs_q;
    num    = use_x ? dw : dh;
    other  = use_x ? cfg_i.height : cfg_i.width;
    other_disp = use_x_q ? dw : dh;
    dvd    = other * num;
    trial  = {rem_q, quo_q[DRAW_W-1]};
    ge     = trial >= den_q;
    diff_x = '0;
    diff_y = '0;
    adj_x  = '0;
    adj_y  = '0;

    unique case (state_q)
      ST_IDLE: ;
      ST_CMP: begin
        xs_d    = prod_a <= prod_b;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        use_x_d  = use_x;
        num480_d = num == COORD_W'(FRAME_HEIGHT);
        den_d    = use_x ? cfg_i.width : cfg_i.height;
        quo_d    = dvd[DRAW_W-1:0];
        rem_d    = '0;
        cnt_d    = '0;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        rem_d = ge ? 12'(trial - den_q) : trial[11:0];
        quo_d = {quo_q[DRAW_W-2:0], ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == LAST_STEP) begin
          state_d = ST_OFFS;
        end
      end
      ST_OFFS: begin
        draw_w_d = use_x_q ? DRAW_W'(other_disp) : quo_q;
        draw_h_d = use_x_q ? quo_q : DRAW_W'(other_disp);
        diff_x   = $signed({1'b0, DRAW_W'(dw)}) - $signed({1'b0, draw_w_d});
        diff_y   = $signed({1'b0, DRAW_W'(dh)}) - $signed({1'b0, draw_h_d});
        adj_x    = diff_x + $signed({{(OFF_W-1){1'b0}}, diff_x[OFF_W-1]});
        adj_y    = diff_y + $signed({{(OFF_W-1){1'b0}}, diff_y[OFF_W-1]});
        off_x_d  = adj_x >>> 1;
        off_y_d  = adj_y >>> 1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    if (start_i) begin
      state_d = ST_CMP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CMP;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xs_q     <= xs_d;
    use_x_q  <= use_x_d;
    num480_q <= num480_d;
    den_q    <= den_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    draw_w_q <= draw_w_d;
    draw_h_q <= draw_h_d;
    off_x_q  <= off_x_d;
    off_y_q  <= off_y_d;
  end

  assign busy_o        = state_q != ST_IDLE;
  assign geom_o.draw_w = draw_w_q;
  assign geom_o.draw_h = draw_h_q;
  assign geom_o.off_x  = off_x_q;
  assign geom_o.off_y  = off_y_q;
  assign geom_o.den    = den_q;
  assign geom_o.num480 = num480_q;

  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !start_i && cnt_q != LAST_STEP) |=> state_q == ST_DIV)
    else $error("divider left early");

  a_fixed_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && use_x_q) |-> draw_w_q == DRAW_W'(dw))
    else $error("scaled axis does not span the display");

endmodule

### hdl/lsag_pipe.sv
// Six-stage address pipeline from display coordinate to source pixel and byte address.
module lsag_pipe import lsag_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  geom_t              geom_i,
  input  logic               busy_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [COORD_W-1:0] screen_x_i,
  input  logic [COORD_W-1:0] screen_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               coord_ok_o,
  output logic               shows_image_o,
  output logic [FIDX_W-1:0]  frame_index_o,
  output logic [SRC_W-1:0]   source_x_o,
  output logic [SRC_W-1:0]   source_y_o,
  output logic [ADDR_W-1:0]  source_byte_address_o
);

  logic [5:0] v_q;
  logic [5:0] adv;
  logic       take;

  always_comb begin
    adv[5] = !v_q[5] || out_ready_i;
    for (int k = 4; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0] && !busy_i;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= take;
      end
      for (int k = 1; k < 6; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 1: bounds, framebuffer index and offsets into the drawn image.
  logic               s1_ok_d, s1_ok_q;
  logic [FIDX_W-1:0]  s1_fidx_d, s1_fidx_q;
  logic [OFF_W-1:0]   s1_dx_d, s1_dx_q, s1_dy_d, s1_dy_q;
  logic [COORD_W-1:0] row, col;

  always_comb begin
    if (cfg_i.portrait) begin
      s1_ok_d = screen_x_i < COORD_W'(FRAME_WIDTH) && screen_y_i < COORD_W'(FRAME_HEIGHT);
      row     = screen_y_i;
      col     = screen_x_i;
    end else begin
      s1_ok_d = screen_x_i < COORD_W'(FRAME_HEIGHT) && screen_y_i < COORD_W'(FRAME_WIDTH);
      row     = COORD_W'(FRAME_LAST_ROW) - screen_x_i;
      col     = screen_y_i;
    end
    s1_fidx_d = FIDX_W'({row, 8'b0}) + FIDX_W'({row, 6'b0}) + FIDX_W'(col);
    s1_dx_d   = OFF_W'($signed({13'b0, screen_x_i}) - $signed(geom_i.off_x));
    s1_dy_d   = OFF_W'($signed({13'b0, screen_y_i}) - $signed(geom_i.off_y));
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_ok_q   <= s1_ok_d;
      s1_fidx_q <= s1_fidx_d;
      s1_dx_q   <= s1_dx_d;
      s1_dy_q   <= s1_dy_d;
    end
  end

  // Stage 2: inside test and scaling products.
  logic              s2_ok_q, s2_shows_d, s2_shows_q;
  logic [FIDX_W-1:0] s2_fidx_q;
  logic [33:0]       mx2, my2;
  logic [DRAW_W-1:0] s2_px_q, s2_py_q;

  always_comb begin
    s2_shows_d = s1_ok_q && !s1_dx_q[OFF_W-1] && !s1_dy_q[OFF_W-1] &&
                 s1_dx_q[DRAW_W-1:0] < geom_i.draw_w && s1_dy_q[DRAW_W-1:0] < geom_i.draw_h;
    mx2 = s1_dx_q[DRAW_W-1:0] * geom_i.den;
    my2 = s1_dy_q[DRAW_W-1:0] * geom_i.den;
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_ok_q    <= s1_ok_q;
      s2_shows_q <= s2_shows_d;
      s2_fidx_q  <= s1_fidx_q;
      s2_px_q    <= mx2[DRAW_W-1:0];
      s2_py_q    <= my2[DRAW_W-1:0];
    end
  end

  // Stage 3: division by the display dimension through a reciprocal.
  logic               s3_ok_q, s3_shows_q;
  logic [FIDX_W-1:0]  s3_fidx_q;
  logic [T_W-1:0]     tx, ty;
  logic [RECIP_W-1:0] recip;
  logic [33:0]        mx3, my3;
  logic [QUO_W-1:0]   s3_qx_q, s3_qy_q;

  always_comb begin
    tx    = geom_i.num480 ? s2_px_q[DRAW_W-1:5] : T_W'(s2_px_q[DRAW_W-1:6]);
    ty    = geom_i.num480 ? s2_py_q[DRAW_W-1:5] : T_W'(s2_py_q[DRAW_W-1:6]);
    recip = geom_i.num480 ? RECIP_DIV15 : RECIP_DIV5;
    mx3   = tx * recip;
    my3   = ty * recip;
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_ok_q    <= s2_ok_q;
      s3_shows_q <= s2_shows_q;
      s3_fidx_q  <= s2_fidx_q;
      s3_qx_q    <= mx3[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
      s3_qy_q    <= my3[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
    end
  end

  // Stage 4: clamp to the last source pixel.
  logic              s4_ok_q, s4_shows_q;
  logic [FIDX_W-1:0] s4_fidx_q;
  logic [SRC_W-1:0]  s4_sx_d, s4_sy_d, s4_sx_q, s4_sy_q;
  logic [DIM_W-1:0]  w_last, h_last;

  always_comb begin
    w_last  = cfg_i.width - DIM_W'(1);
    h_last  = cfg_i.height - DIM_W'(1);
    s4_sx_d = (s3_qx_q >= cfg_i.width) ? w_last[SRC_W-1:0] : s3_qx_q[SRC_W-1:0];
    s4_sy_d = (s3_qy_q >= cfg_i.height) ? h_last[SRC_W-1:0] : s3_qy_q[SRC_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s4_ok_q    <= s3_ok_q;
      s4_shows_q <= s3_shows_q;
      s4_fidx_q  <= s3_fidx_q;
      s4_sx_q    <= s4_sx_d;
      s4_sy_q    <= s4_sy_d;
    end
  end

  // Stage 5: linear pixel index.
  logic              s5_ok_q, s5_shows_q;
  logic [FIDX_W-1:0] s5_fidx_q;
  logic [SRC_W-1:0]  s5_sx_q, s5_sy_q;
  logic [24:0]       m5;
  logic [LIN_W-1:0]  s5_lin_q;

  assign m5 = s4_sy_q * cfg_i.width;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s5_ok_q    <= s4_ok_q;
      s5_shows_q <= s4_shows_q;
      s5_fidx_q  <= s4_fidx_q;
      s5_sx_q    <= s4_sx_q;
      s5_sy_q    <= s4_sy_q;
      s5_lin_q   <= m5[LIN_W-1:0] + LIN_W'(s4_sx_q);
    end
  end

  // Stage 6: byte address and output register.
  logic [ADDR_W-1:0] lin_ext, addr;
  logic              s6_ok_q, s6_shows_q;
  logic [FIDX_W-1:0] s6_fidx_q;
  logic [SRC_W-1:0]  s6_sx_q, s6_sy_q;
  logic [ADDR_W-1:0] s6_addr_q;

  always_comb begin
    lin_ext = ADDR_W'(s5_lin_q);
    case (cfg_i.bpp)
      3'd1:    addr = lin_ext;
      3'd2:    addr = lin_ext << 1;
      3'd3:    addr = (lin_ext << 1) + lin_ext;
      default: addr = lin_ext << 2;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      s6_ok_q    <= s5_ok_q;
      s6_shows_q <= s5_shows_q;
      s6_fidx_q  <= s5_ok_q ? s5_fidx_q : '0;
      s6_sx_q    <= s5_shows_q ? s5_sx_q : '0;
      s6_sy_q    <= s5_shows_q ? s5_sy_q : '0;
      s6_addr_q  <= s5_shows_q ? addr : '0;
    end
  end

  assign out_valid_o           = v_q[5];
  assign coord_ok_o            = s6_ok_q;
  assign shows_image_o         = s6_shows_q;
  assign frame_index_o         = s6_fidx_q;
  assign source_x_o            = s6_sx_q;
  assign source_y_o            = s6_sy_q;
  assign source_byte_address_o = s6_addr_q;

  a_shows_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && shows_image_o) |-> coord_ok_o)
    else $error("image pixel outside the display");

  a_src_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && shows_image_o) |->
      ({1'b0, source_x_o} < cfg_i.width && {1'b0, source_y_o} < cfg_i.height))
    else $error("source pixel beyond the image");

  a_off_display_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !coord_ok_o) |-> (frame_index_o == '0 && source_byte_address_o == '0))
    else $error("off-display item carries data");

endmodule

### hdl/letterbox_scaler_address_generator.sv
// Top level of the letterbox scaler address generator.
// The block maps display coordinates to a framebuffer index and the nearest source pixel with
// its byte address; each item passes through the registered stages of the address pipeline,
// and a full pipeline sustains one item per cycle while out_ready_i is held and no geometry
// update runs. After reset and after every register write a geometry sequencer (mostly a
// 21-step restoring divider) recomputes draw size and centering offsets, and no item is accepted while it runs.
module letterbox_scaler_address_generator import lsag_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [COORD_W-1:0] screen_x_i,
  input  logic [COORD_W-1:0] screen_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               coord_ok_o,
  output logic               shows_image_o,
  output logic [FIDX_W-1:0]  frame_index_o,
  output logic [SRC_W-1:0]   source_x_o,
  output logic [SRC_W-1:0]   source_y_o,
  output logic [ADDR_W-1:0]  source_byte_address_o
);

  cfg_t  cfg;
  geom_t geom;
  logic  cfg_wr;
  logic  busy;

  lsag_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .wr_o    (cfg_wr)
  );

  lsag_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .start_i (cfg_wr),
    .geom_o  (geom),
    .busy_o  (busy)
  );

  lsag_pipe u_pipe (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg),
    .geom_i                (geom),
    .busy_i                (busy),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .screen_x_i            (screen_x_i),
    .screen_y_i            (screen_y_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .coord_ok_o            (coord_ok_o),
    .shows_image_o         (shows_image_o),
    .frame_index_o         (frame_index_o),
    .source_x_o            (source_x_o),
    .source_y_o            (source_y_o),
    .source_byte_address_o (source_byte_address_o)
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready_o)
    else $error("item accepted during geometry update");

endmodule

### tb/tb_letterbox_scaler_address_generator.sv
// Self-checking testbench for the letterbox scaler address generator with an APB register port.
module tb_letterbox_scaler_address_generator;
  import lsag_pkg::*;

  localparam int QUIET_LIMIT      = 4000;
  localparam int RANDOM_BLOCKS    = 12;
  localparam int BLOCK_ITEMS      = 160;
  localparam int MAX_BPP          = 4;
  localparam int REG_FIRST_UNUSED = 5;
  localparam int NUM_REG_SLOTS    = 8;
  localparam int MAX_COORD        = (1 << COORD_W) - 1;
  localparam int MAX_DIM_FIELD    = (1 << DIM_W) - 1;

  typedef struct packed {
    logic              ok;
    logic              shows;
    logic [FIDX_W-1:0] fidx;
    logic [SRC_W-1:0]  src_x;
    logic [SRC_W-1:0]  src_y;
    logic [ADDR_W-1:0] addr;
  } pix_res_t;

  typedef struct packed {
    cfg_t               cfg;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic               known;
    pix_res_t           want;
  } row_t;

  localparam pix_res_t NO_PIXEL = '0;

  localparam cfg_t CFG_RESET     = '{RESET_IMAGE_WIDTH, RESET_IMAGE_HEIGHT, RESET_BPP, 1'b0, 1'b0};
  localparam cfg_t CFG_PORTRAIT  = '{13'd320, 13'd480, 3'd3, 1'b0, 1'b1};
  localparam cfg_t CFG_FILL      = '{13'd320, 13'd480, 3'd3, 1'b1, 1'b0};
  localparam cfg_t CFG_FILL_PORT = '{13'd320, 13'd480, 3'd3, 1'b1, 1'b1};
  localparam cfg_t CFG_ZERO      = '{13'd0, 13'd0, 3'd0, 1'b0, 1'b0};
  localparam cfg_t CFG_ONES      = '{13'h1FFF, 13'h1FFF, 3'd7, 1'b1, 1'b1};
  localparam cfg_t CFG_WIDE      = '{13'd4096, 13'd1, 3'd4, 1'b0, 1'b0};
  localparam cfg_t CFG_TALL      = '{13'd1, 13'd4096, 3'd5, 1'b1, 1'b0};
  localparam cfg_t CFG_MAX       = '{13'd4096, 13'd4096, 3'd4, 1'b1, 1'b1};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [COORD_W-1:0] screen_x_i = '0;
  logic [COORD_W-1:0] screen_y_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               coord_ok_o;
  logic               shows_image_o;
  logic [FIDX_W-1:0]  frame_index_o;
  logic [SRC_W-1:0]   source_x_o;
  logic [SRC_W-1:0]   source_y_o;
  logic [ADDR_W-1:0]  source_byte_address_o;

  letterbox_scaler_address_generator u_top (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .screen_x_i            (screen_x_i),
    .screen_y_i            (screen_y_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .coord_ok_o            (coord_ok_o),
    .shows_image_o         (shows_image_o),
    .frame_index_o         (frame_index_o),
    .source_x_o            (source_x_o),
    .source_y_o            (source_y_o),
    .source_byte_address_o (source_byte_address_o)
  );

  cfg_t     live_cfg = CFG_RESET;
  pix_res_t pending_pix[$];
  row_t     directed_rows[$];
  int       mismatch_cnt = 0;
  int       quiet_cycles = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  pix_res_t got_pix;
  pix_res_t want_pix;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic pix_res_t map_pixel(cfg_t c, logic [COORD_W-1:0] sx,
                                         logic [COORD_W-1:0] sy);
    longint x, y, dw, dh, w, h, bpp, num, den;
    longint draw_w, draw_h, off_x, off_y, dx, dy, src_x, src_y;
    logic   pick_x;
    pix_res_t r;
    r = NO_PIXEL;
    x = sx;
    y = sy;
    dw = c.portrait ? FRAME_WIDTH : FRAME_HEIGHT;
    dh = c.portrait ? FRAME_HEIGHT : FRAME_WIDTH;
    w = (c.width == 0) ? 1 : (c.width > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : c.width;
    h = (c.height == 0) ? 1 : (c.height > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : c.height;
    bpp = (c.bpp == 0) ? 1 : (c.bpp > MAX_BPP) ? MAX_BPP : c.bpp;
    if (x >= dw || y >= dh) begin
      return r;
    end
    r.ok = 1'b1;
    r.fidx = c.portrait ? FIDX_W'(y * FRAME_WIDTH + x)
                        : FIDX_W'((FRAME_LAST_ROW - x) * FRAME_WIDTH + y);
    pick_x = (dw * h <= dh * w) ^ c.fill;
    num = pick_x ? dw : dh;
    den = pick_x ? w : h;
    draw_w = (w * num) / den;
    draw_h = (h * num) / den;
    off_x = (dw - draw_w) / 2;
    off_y = (dh - draw_h) / 2;
    dx = x - off_x;
    dy = y - off_y;
    if (dx >= 0 && dx < draw_w && dy >= 0 && dy < draw_h) begin
      src_x = (dx * den) / num;
      src_y = (dy * den) / num;
      if (src_x >= w) src_x = w - 1;
      if (src_y >= h) src_y = h - 1;
      r.shows = 1'b1;
      r.src_x = SRC_W'(src_x);
      r.src_y = SRC_W'(src_y);
      r.addr = ADDR_W'((src_y * w + src_x) * bpp);
    end
    return r;
  endfunction

  task automatic add_row(cfg_t c, logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                         logic known, pix_res_t want);
    directed_rows.push_back('{c, sx, sy, known, want});
  endtask

  task automatic write_reg(logic [2:0] idx, logic [PDATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_cfg(cfg_t c);
    settle();
    write_reg(REG_IMAGE_WIDTH, {19'($urandom), c.width});
    write_reg(REG_IMAGE_HEIGHT, {19'($urandom), c.height});
    write_reg(REG_BYTES_PER_PIXEL, {29'($urandom), c.bpp});
    write_reg(REG_FILL_MODE, {31'($urandom), c.fill});
    write_reg(REG_PORTRAIT, {31'($urandom), c.portrait});
    write_reg(3'($urandom_range(REG_FIRST_UNUSED, NUM_REG_SLOTS - 1)), $urandom);
    live_cfg = c;
  endtask

  task automatic push_coord(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy, pix_res_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    screen_x_i <= sx;
    screen_y_i <= sy;
    do @(posedge clk_i); while (!in_ready_o);
    pending_pix.push_back(want);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_pix = '{coord_ok_o, shows_image_o, frame_index_o, source_x_o, source_y_o,
                  source_byte_address_o};
      if (pending_pix.size() == 0) begin
        if (mismatch_cnt < 10) begin
          $display("unexpected item: ok=%0d img=%0d fidx=%0d sx=%0d sy=%0d addr=%0d",
                   got_pix.ok, got_pix.shows, got_pix.fidx, got_pix.src_x, got_pix.src_y,
                   got_pix.addr);
        end
        mismatch_cnt++;
      end else begin
        want_pix = pending_pix.pop_front();
        if (got_pix.ok !== want_pix.ok || got_pix.shows !== want_pix.shows ||
            got_pix.fidx !== want_pix.fidx || got_pix.src_x !== want_pix.src_x ||
            got_pix.src_y !== want_pix.src_y || got_pix.addr !== want_pix.addr) begin
          if (mismatch_cnt < 10) begin
            $display("mismatch: exp ok=%0d img=%0d fidx=%0d sx=%0d sy=%0d addr=%0d",
                     want_pix.ok, want_pix.shows, want_pix.fidx, want_pix.src_x,
                     want_pix.src_y, want_pix.addr);
            $display("          got ok=%0d img=%0d fidx=%0d sx=%0d sy=%0d addr=%0d",
                     got_pix.ok, got_pix.shows, got_pix.fidx, got_pix.src_x,
                     got_pix.src_y, got_pix.addr);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_letterbox_scaler_address_generator: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_t               nc;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    int                 dw;
    int                 dh;

    add_row(CFG_RESET, 9'd0, 9'd0, 1'b1, '{1'b1, 1'b0, 18'd153280, 12'd0, 12'd0, 26'd0});
    add_row(CFG_RESET, 9'd133, 9'd0, 1'b1, '{1'b1, 1'b1, 18'd110720, 12'd0, 12'd0, 26'd0});
    add_row(CFG_RESET, 9'd479, 9'd319, 1'b1, '{1'b1, 1'b0, 18'd319, 12'd0, 12'd0, 26'd0});
    add_row(CFG_RESET, 9'd480, 9'd0, 1'b1, NO_PIXEL);
    add_row(CFG_RESET, 9'd0, 9'd320, 1'b1, NO_PIXEL);
    add_row(CFG_RESET, 9'd511, 9'd511, 1'b1, NO_PIXEL);
    add_row(CFG_RESET, 9'd345, 9'd319, 1'b0, NO_PIXEL);
    add_row(CFG_PORTRAIT, 9'd0, 9'd0, 1'b0, NO_PIXEL);
    add_row(CFG_PORTRAIT, 9'd319, 9'd479, 1'b0, NO_PIXEL);
    add_row(CFG_PORTRAIT, 9'd320, 9'd0, 1'b1, NO_PIXEL);
    add_row(CFG_PORTRAIT, 9'd0, 9'd480, 1'b1, NO_PIXEL);
    add_row(CFG_FILL, 9'd0, 9'd0, 1'b0, NO_PIXEL);
    add_row(CFG_FILL, 9'd240, 9'd160, 1'b0, NO_PIXEL);
    add_row(CFG_FILL, 9'd479, 9'd319, 1'b0, NO_PIXEL);
    add_row(CFG_FILL_PORT, 9'd160, 9'd240, 1'b0, NO_PIXEL);
    add_row(CFG_ZERO, 9'd240, 9'd160, 1'b0, NO_PIXEL);
    add_row(CFG_ZERO, 9'd0, 9'd0, 1'b0, NO_PIXEL);
    add_row(CFG_ONES, 9'd319, 9'd479, 1'b0, NO_PIXEL);
    add_row(CFG_ONES, 9'd0, 9'd0, 1'b0, NO_PIXEL);
    add_row(CFG_WIDE, 9'd479, 9'd319, 1'b0, NO_PIXEL);
    add_row(CFG_WIDE, 9'd240, 9'd160, 1'b0, NO_PIXEL);
    add_row(CFG_TALL, 9'd240, 9'd160, 1'b0, NO_PIXEL);
    add_row(CFG_MAX, 9'd319, 9'd479, 1'b0, NO_PIXEL);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg != live_cfg) begin
        load_cfg(directed_rows[i].cfg);
      end
      push_coord(directed_rows[i].sx, directed_rows[i].sy,
                 directed_rows[i].known ? directed_rows[i].want
                                        : map_pixel(live_cfg, directed_rows[i].sx,
                                                    directed_rows[i].sy));
    end

    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      case ($urandom_range(0, 7))
        0: nc.width = '0;
        1: nc.width = DIM_W'(1);
        2: nc.width = DIM_W'(MAX_IMAGE_DIM);
        3: nc.width = DIM_W'($urandom_range(MAX_IMAGE_DIM + 1, MAX_DIM_FIELD));
        4: nc.width = DIM_W'($urandom_range(1, 64));
        default: nc.width = DIM_W'($urandom_range(1, MAX_IMAGE_DIM));
      endcase
      case ($urandom_range(0, 7))
        0: nc.height = '0;
        1: nc.height = DIM_W'(1);
        2: nc.height = DIM_W'(MAX_IMAGE_DIM);
        3: nc.height = DIM_W'($urandom_range(MAX_IMAGE_DIM + 1, MAX_DIM_FIELD));
        4: nc.height = DIM_W'($urandom_range(1, 64));
        default: nc.height = DIM_W'($urandom_range(1, MAX_IMAGE_DIM));
      endcase
      nc.bpp = BPP_W'($urandom);
      nc.fill = 1'($urandom);
      nc.portrait = 1'($urandom);
      load_cfg(nc);
      case (blk % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 87; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 87; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      dw = live_cfg.portrait ? FRAME_WIDTH : FRAME_HEIGHT;
      dh = live_cfg.portrait ? FRAME_HEIGHT : FRAME_WIDTH;
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 85) begin
          sx = COORD_W'($urandom_range(0, dw - 1));
          sy = COORD_W'($urandom_range(0, dh - 1));
        end else begin
          sx = COORD_W'($urandom_range(0, MAX_COORD));
          sy = COORD_W'($urandom_range(0, MAX_COORD));
        end
        push_coord(sx, sy, map_pixel(live_cfg, sx, sy));
      end
    end

    settle();
    repeat (16) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_pix.size() == 0) begin
      $display("tb_letterbox_scaler_address_generator: PASS");
    end else begin
      $display("tb_letterbox_scaler_address_generator: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/lsag_pkg.sv
hdl/lsag_regs.sv
hdl/lsag_geom.sv
hdl/lsag_pipe.sv
hdl/letterbox_scaler_address_generator.sv
tb/tb_letterbox_scaler_address_generator.sv
